// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/asc_pkg.sv -----
package asc_pkg;

    localparam int LUX_W = 16;

    localparam logic [9:0]  MS_PER_S    = 10'd1000;
    localparam logic [6:0]  PCT_FULL    = 7'd100;
    // floor(dt * 1048 / 2^20) is dt/1000 or one short for any 16-bit dt
    localparam logic [10:0] RECIP_K     = 11'd1048;
    localparam int          RECIP_SHIFT = 20;

    localparam logic [1:0] MODE_SENSOR = 2'd0;
    localparam logic [1:0] MODE_ON     = 2'd1;
    localparam logic [1:0] MODE_OFF    = 2'd2;

    localparam logic [2:0] REG_NIGHT_LUX = 3'd0;
    localparam logic [2:0] REG_DAY_LUX   = 3'd1;
    localparam logic [2:0] REG_HOLD_S    = 3'd2;
    localparam logic [2:0] REG_STBY_PCT  = 3'd3;
    localparam logic [2:0] REG_ACT_PCT   = 3'd4;
    localparam logic [2:0] REG_RUN_MODE  = 3'd5;

    typedef enum logic [1:0] {
        ST_DAY     = 2'd0,
        ST_STANDBY = 2'd1,
        ST_ACTIVE  = 2'd2
    } asc_state_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux_reading;
        logic             motion_seen;
        logic [15:0]      elapsed_ms;
    } asc_in_t;

    typedef struct packed {
        logic [1:0]  light_state;
        logic        relay_on;
        logic [6:0]  brightness_cmd;
        logic [15:0] hold_left_s;
    } asc_out_t;

    typedef struct packed {
        logic [LUX_W-1:0] night_lux_threshold;
        logic [LUX_W-1:0] day_lux_threshold;
        logic [15:0]      hold_seconds;
        logic [6:0]       standby_percent;
        logic [6:0]       active_percent;
        logic [1:0]       run_mode;
    } asc_cfg_t;

    // hold timer kept as whole seconds plus milliseconds (ms < 1000)
    typedef struct packed {
        logic [15:0] sec;
        logic [9:0]  ms;
    } asc_timer_t;

    // elapsed tick time split the same way
    typedef struct packed {
        logic [6:0] sec;
        logic [9:0] ms;
    } asc_dt_t;

endpackage

// ----- hw/rtl/asc_msdiv.sv -----
module asc_msdiv (
    input  logic                aclk,
    input  logic                en_mul,
    input  logic                en_fix,
    input  logic [15:0]         dt_i,
    output asc_pkg::asc_dt_t    dt_o
);

    logic [26:0] prod_reg;
    logic [15:0] dt_d_reg;
    asc_pkg::asc_dt_t split_reg;

    logic [6:0]  q_est;
    logic [16:0] r_est;
    asc_pkg::asc_dt_t split_next;

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod_reg <= 27'(dt_i) * 27'(asc_pkg::RECIP_K);
            dt_d_reg <= dt_i;
        end
        if (en_fix) begin
            split_reg <= split_next;
        end
    end

    assign q_est = prod_reg[asc_pkg::RECIP_SHIFT +: 7];
    assign r_est = 17'(dt_d_reg) - 17'(q_est) * 17'(asc_pkg::MS_PER_S);

    // estimate may be one second short; remainder then lies in 1000..1999
    always_comb begin
        if (r_est >= 17'(asc_pkg::MS_PER_S)) begin
            split_next.sec = q_est + 7'd1;
            split_next.ms  = 10'(r_est - 17'(asc_pkg::MS_PER_S));
        end else begin
            split_next.sec = q_est;
            split_next.ms  = 10'(r_est);
        end
    end

    assign dt_o = split_reg;

endmodule

// ----- hw/rtl/asc_core.sv -----
module asc_core (
    input  asc_pkg::asc_cfg_t         cfg,
    input  asc_pkg::asc_state_t       state,
    input  asc_pkg::asc_timer_t       timer,
    input  logic [asc_pkg::LUX_W-1:0] lux,
    input  logic                      motion,
    input  asc_pkg::asc_dt_t          dt,
    output asc_pkg::asc_state_t       state_next,
    output asc_pkg::asc_timer_t       timer_next,
    output asc_pkg::asc_out_t         result
);

    logic       timer_zero;
    logic       borrow;
    logic       expire;
    logic       is_daylight;
    logic [9:0] ms_dec;
    logic [10:0] ms_wrap;
    logic [15:0] sec_dec;
    logic [6:0] stby_pct;
    logic [6:0] act_pct;
    logic       relay;
    logic [6:0] bright;
    asc_pkg::asc_timer_t reload;

    assign timer_zero  = (timer.sec == 16'd0) && (timer.ms == 10'd0);
    assign borrow      = timer.ms < dt.ms;
    assign ms_wrap     = 11'(timer.ms) + 11'(asc_pkg::MS_PER_S) - 11'(dt.ms);
    assign ms_dec      = borrow ? ms_wrap[9:0] : (timer.ms - dt.ms);
    assign sec_dec     = timer.sec - 16'(dt.sec) - 16'(borrow);
    assign expire      = (timer.sec < 16'(dt.sec)) ||
                         ((timer.sec == 16'(dt.sec)) && (timer.ms <= dt.ms));
    assign is_daylight = lux > cfg.day_lux_threshold;
    assign reload.sec  = cfg.hold_seconds;
    assign reload.ms   = 10'd0;

    assign stby_pct = (cfg.standby_percent > asc_pkg::PCT_FULL) ?
                      asc_pkg::PCT_FULL : cfg.standby_percent;
    assign act_pct  = (cfg.active_percent > asc_pkg::PCT_FULL) ?
                      asc_pkg::PCT_FULL : cfg.active_percent;

    // relay and brightness follow the run mode and the state held at the start of the tick
    always_comb begin
        state_next = state;
        timer_next = timer;
        relay      = 1'b0;
        bright     = 7'd0;
        priority if (cfg.run_mode == asc_pkg::MODE_ON) begin
            relay      = 1'b1;
            bright     = asc_pkg::PCT_FULL;
            state_next = asc_pkg::ST_ACTIVE;
        end else if (cfg.run_mode == asc_pkg::MODE_OFF) begin
            state_next = asc_pkg::ST_DAY;
        end else begin
            unique case (state)
                asc_pkg::ST_STANDBY: begin
                    relay  = 1'b1;
                    bright = stby_pct;
                    if (is_daylight) begin
                        state_next = asc_pkg::ST_DAY;
                    end else if (motion) begin
                        timer_next = reload;
                        state_next = asc_pkg::ST_ACTIVE;
                    end
                end
                asc_pkg::ST_ACTIVE: begin
                    relay  = 1'b1;
                    bright = act_pct;
                    if (motion) begin
                        timer_next = reload;
                    end else if (!timer_zero) begin
                        if (expire) begin
                            timer_next = '0;
                            state_next = asc_pkg::ST_STANDBY;
                        end else begin
                            timer_next.sec = sec_dec;
                            timer_next.ms  = ms_dec;
                        end
                    end else begin
                        state_next = asc_pkg::ST_STANDBY;
                    end
                    // daylight wins over motion and timer
                    if (is_daylight) begin
                        state_next = asc_pkg::ST_DAY;
                    end
                end
                default: begin
                    timer_next = '0;
                    state_next = (lux < cfg.night_lux_threshold) ?
                                 asc_pkg::ST_STANDBY : asc_pkg::ST_DAY;
                end
            endcase
        end
    end

    assign result.light_state    = state_next;
    assign result.relay_on       = relay;
    assign result.brightness_cmd = bright;
    assign result.hold_left_s    = timer_next.sec + 16'(timer_next.ms != 10'd0);

endmodule

// ----- hw/rtl/adaptive_streetlight_controller_unit.sv -----
// Streetlight controller: one sensor tick in, one lamp command out.
// s_data carries lux, motion flag and elapsed ms; a request is taken when
// s_valid and s_ready are high. A tick with zero elapsed time is taken and
// dropped: it changes nothing and gives no result.
// m_data carries the new state, relay, brightness and hold time left in
// whole seconds (rounded up), under m_valid/m_ready.
// Throughput: one request per cycle while m_ready does not stall the
// output; the state and hold timer close their loop at the last stage,
// so ticks follow each other back to back. The two stages before it
// split elapsed ms into seconds and ms with a reciprocal multiply.
// A stalled m_ready holds the result; the stages behind fill up and
// s_ready drops only once all of them hold a request.
// The user must write the registers through cfg_we/cfg_index/cfg_wdata
// only while idle; the block itself does not enforce this.
// Reset (aresetn low, synchronous) empties the pipeline, restores the
// register defaults, sets the day state and clears the hold timer.
`include "assert_macros.svh"

module adaptive_streetlight_controller_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  asc_pkg::asc_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output asc_pkg::asc_out_t  m_data
);

    asc_pkg::asc_cfg_t   cfg_reg;
    asc_pkg::asc_state_t state_reg;
    asc_pkg::asc_timer_t timer_reg;
    asc_pkg::asc_state_t state_next;
    asc_pkg::asc_timer_t timer_next;
    asc_pkg::asc_out_t   result;
    asc_pkg::asc_dt_t    dt_split;

    logic a_valid_reg, b_valid_reg, c_valid_reg, m_valid_reg;
    asc_pkg::asc_in_t a_data_reg;
    logic [asc_pkg::LUX_W-1:0] b_lux_reg, c_lux_reg;
    logic b_motion_reg, c_motion_reg;
    asc_pkg::asc_out_t m_data_reg;

    logic s_fire, out_ready, adv_a, adv_b, adv_c, b_ready, c_ready;

    assign out_ready = !m_valid_reg || m_ready;
    assign adv_c     = c_valid_reg && out_ready;
    assign c_ready   = !c_valid_reg || out_ready;
    assign adv_b     = b_valid_reg && c_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign adv_a     = a_valid_reg && b_ready;
    assign s_ready   = !a_valid_reg || b_ready;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.night_lux_threshold <= asc_pkg::LUX_W'(150);
            cfg_reg.day_lux_threshold   <= asc_pkg::LUX_W'(250);
            cfg_reg.hold_seconds        <= 16'd15;
            cfg_reg.standby_percent     <= 7'd25;
            cfg_reg.active_percent      <= 7'd100;
            cfg_reg.run_mode            <= asc_pkg::MODE_SENSOR;
        end else if (cfg_we) begin
            unique case (cfg_index)
                asc_pkg::REG_NIGHT_LUX: cfg_reg.night_lux_threshold <= cfg_wdata;
                asc_pkg::REG_DAY_LUX:   cfg_reg.day_lux_threshold   <= cfg_wdata;
                asc_pkg::REG_HOLD_S:    cfg_reg.hold_seconds        <= cfg_wdata;
                asc_pkg::REG_STBY_PCT:  cfg_reg.standby_percent     <= cfg_wdata[6:0];
                asc_pkg::REG_ACT_PCT:   cfg_reg.active_percent      <= cfg_wdata[6:0];
                asc_pkg::REG_RUN_MODE:  cfg_reg.run_mode            <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // pipeline valids, state and hold timer; zero-ms ticks never enter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            state_reg   <= asc_pkg::ST_DAY;
            timer_reg   <= '0;
        end else begin
            if (s_fire) begin
                a_valid_reg <= s_data.elapsed_ms != 16'd0;
            end else if (adv_a) begin
                a_valid_reg <= 1'b0;
            end
            if (adv_a) begin
                b_valid_reg <= 1'b1;
            end else if (adv_b) begin
                b_valid_reg <= 1'b0;
            end
            if (adv_b) begin
                c_valid_reg <= 1'b1;
            end else if (adv_c) begin
                c_valid_reg <= 1'b0;
            end
            if (adv_c) begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
                timer_reg   <= timer_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_data_reg <= s_data;
        end
        if (adv_a) begin
            b_lux_reg    <= a_data_reg.lux_reading;
            b_motion_reg <= a_data_reg.motion_seen;
        end
        if (adv_b) begin
            c_lux_reg    <= b_lux_reg;
            c_motion_reg <= b_motion_reg;
        end
        if (adv_c) begin
            m_data_reg <= result;
        end
    end

    asc_msdiv u_msdiv (
        .aclk   (aclk),
        .en_mul (adv_a),
        .en_fix (adv_b),
        .dt_i   (a_data_reg.elapsed_ms),
        .dt_o   (dt_split)
    );

    asc_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .timer      (timer_reg),
        .lux        (c_lux_reg),
        .motion     (c_motion_reg),
        .dt         (dt_split),
        .state_next (state_next),
        .timer_next (timer_next),
        .result     (result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_IMPL(a_timer_ms_range, 1'b1, timer_reg.ms < asc_pkg::MS_PER_S)
    `ASSERT_IMPL(a_bright_range, m_valid_reg, m_data_reg.brightness_cmd <= asc_pkg::PCT_FULL)
    `ASSERT_NEXT(a_last_stage_holds, c_valid_reg && !out_ready, c_valid_reg)

endmodule
